// ----- hw/rtl/color_gradient_ramp_defines.svh -----
// Assertion helpers for the colour gradient ramp.
`ifndef COLOR_GRADIENT_RAMP_DEFINES_SVH
`define COLOR_GRADIENT_RAMP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CGR_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CGR_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cgr_pkg.sv -----
`timescale 1ns / 1ps

package cgr_pkg;

    localparam logic [1:0] ACT_EVAL = 2'd0;
    localparam logic [1:0] ACT_LOAD = 2'd1;
    localparam logic [1:0] ACT_INIT = 2'd2;

    // blend factor source
    localparam logic [1:0] FK_ZERO = 2'd0;
    localparam logic [1:0] FK_ONE  = 2'd1;
    localparam logic [1:0] FK_DIV  = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPW    = 2;
    localparam int QCW    = 3;

    localparam int STOP_W = 48;

    typedef struct packed {
        logic [2:0]  seg;
        logic        upd;
        logic [1:0]  kind;
        logic [15:0] num;
        logic [15:0] den;
        logic [31:0] c0;
        logic [31:0] c1;
    } job_t;

    typedef struct packed {
        logic       push;
    } q_stat_t;

endpackage

// ----- hw/rtl/color_gradient_ramp.sv -----
`timescale 1ns / 1ps
// Colour gradient ramp: piecewise-linear RGBA lookup over a table of stops.
// Input channel (in_valid / in_stall): one transaction per action. A load
// writes one stop and gives no result; init and evaluate give one result
// transaction on the output channel (out_valid / out_stall), in order.
// stop_count is to be written through stop_count_we / stop_count_wdata
// only while idle, a duty of the user that the block does not enforce.
// Throughput: one transaction per cycle unless stalled; the 16-step
// restoring divider is fully pipelined, one quotient bit per stage, as is
// the 4-channel blend. Result path: stop table read, queue, divider,
// multiply, output register. A load is visible to an evaluate accepted in
// the very next cycle. Reset clears all valid flags and the queue and sets
// stop_count to 1; the stop table holds no defined contents until loaded.
// When the receiver stalls a result the back end holds; the front accepts
// until queue and table read stage hold 4 entries, then raises in_stall.

`include "color_gradient_ramp_defines.svh"

module color_gradient_ramp #(
    parameter int MAX_STOPS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       stop_count_we,
    input  logic [3:0] stop_count_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [2:0] entry_index,
    input  logic [15:0] key_percent,
    input  logic [2:0] current_segment,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    input  logic [7:0] alpha_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] segment_out,
    output logic       color_updated,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic [7:0] alpha_out
);
    logic [3:0] stop_count_reg;
    logic q_push, q_pop, q_valid;
    logic [cgr_pkg::QCW-1:0] q_count;
    cgr_pkg::job_t wr_job, rd_job;
    cgr_pkg::q_stat_t wr_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= 4'd1;
        end
        else if (stop_count_we)
        begin
            stop_count_reg <= stop_count_wdata;
        end
    end

    cgr_front #(.MAX_STOPS(MAX_STOPS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .entry_index(entry_index), .key_percent(key_percent),
        .current_segment(current_segment),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
        .stop_count(stop_count_reg), .q_count(q_count),
        .q_push(q_push), .q_job(wr_job)
    );

    assign wr_stat.push  = q_push;

    cgr_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr(wr_stat), .wr_job(wr_job),
        .pop(q_pop), .rd_valid(q_valid), .rd_job(rd_job), .count(q_count)
    );

    cgr_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_job(rd_job), .q_pop(q_pop),
        .out_valid(out_valid), .out_stall(out_stall),
        .segment_out(segment_out), .color_updated(color_updated),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .alpha_out(alpha_out)
    );

    `CGR_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1,
        (32'(q_count) <= cgr_pkg::QDEPTH), "queue over capacity")
    `CGR_ASSERT_NEXT(a_result_queued, clk, rst_n,
        (in_valid && !in_stall && ((action == cgr_pkg::ACT_EVAL) || (action == cgr_pkg::ACT_INIT))),
        q_push, "accepted action produced no queue entry")
    `CGR_ASSERT_NOW(a_kept_colour_zero, clk, rst_n, (out_valid && !color_updated),
        ((red_out == 8'd0) && (green_out == 8'd0) && (blue_out == 8'd0) && (alpha_out == 8'd0)),
        "kept colour not zero")
endmodule

// ----- hw/rtl/cgr_ram.sv -----
`timescale 1ns / 1ps

module cgr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/cgr_front.sv -----
`timescale 1ns / 1ps

module cgr_front #(
    parameter int MAX_STOPS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic [2:0]           entry_index,
    input  logic [15:0]          key_percent,
    input  logic [2:0]           current_segment,
    input  logic [7:0]           red_in,
    input  logic [7:0]           green_in,
    input  logic [7:0]           blue_in,
    input  logic [7:0]           alpha_in,
    input  logic [3:0]           stop_count,
    input  logic [cgr_pkg::QCW-1:0] q_count,
    output logic                 q_push,
    output cgr_pkg::job_t        q_job
);
    localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CW = $clog2(MAX_STOPS + 1);

    logic accept;
    logic we;
    logic [2:0] seg_sel;
    logic [3:0] seg4;
    logic [IW-1:0] addr_a, addr_b, addr_c, waddr;
    logic [cgr_pkg::STOP_W-1:0] wdata, d_a, d_b, d_c;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_init_reg;
    logic [15:0] s1_age_reg;
    logic [2:0]  s1_seg_reg;

    assign in_stall = ({1'b0, q_count} + {{cgr_pkg::QCW{1'b0}}, s1_valid_reg})
                      >= (cgr_pkg::QCW+1)'(cgr_pkg::QDEPTH);
    assign accept = in_valid && !in_stall;
    assign we     = accept && (action == cgr_pkg::ACT_LOAD) && (32'(entry_index) < MAX_STOPS);
    assign waddr  = IW'(entry_index);
    assign wdata  = {key_percent, red_in, green_in, blue_in, alpha_in};

    assign seg_sel = (action == cgr_pkg::ACT_INIT) ? 3'd0 : current_segment;
    assign seg4    = {1'b0, seg_sel};
    assign addr_a  = IW'(seg4);
    assign addr_b  = IW'(seg4 + 4'd1);
    assign addr_c  = IW'(seg4 + 4'd2);

    cgr_ram #(.WIDTH(cgr_pkg::STOP_W), .DEPTH(MAX_STOPS)) u_ram_a (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(addr_a), .rdata(d_a)
    );
    cgr_ram #(.WIDTH(cgr_pkg::STOP_W), .DEPTH(MAX_STOPS)) u_ram_b (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(addr_b), .rdata(d_b)
    );
    cgr_ram #(.WIDTH(cgr_pkg::STOP_W), .DEPTH(MAX_STOPS)) u_ram_c (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(addr_c), .rdata(d_c)
    );

    assign s1_valid_next = accept && ((action == cgr_pkg::ACT_EVAL) ||
                                      (action == cgr_pkg::ACT_INIT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_init_reg <= (action == cgr_pkg::ACT_INIT);
            s1_age_reg  <= key_percent;
            s1_seg_reg  <= current_segment;
        end
    end

    // classification
    logic [CW-1:0] n, last;
    logic [15:0] ka, kb, kc, k0, k1;
    logic adv;
    logic [3:0] s2;

    assign ka = d_a[47:32];
    assign kb = d_b[47:32];
    assign kc = d_c[47:32];

    always_comb
    begin
        if (stop_count == 4'd0)
        begin
            n = CW'(1);
        end
        else if (32'(stop_count) > MAX_STOPS)
        begin
            n = CW'(MAX_STOPS);
        end
        else
        begin
            n = CW'(stop_count);
        end
        last = n - CW'(1);

        adv = (s1_age_reg >= kb);
        s2  = {1'b0, s1_seg_reg} + {3'b0, adv};
        k0  = adv ? kb : ka;
        k1  = adv ? kc : kb;

        q_job.seg  = s1_seg_reg;
        q_job.upd  = 1'b0;
        q_job.kind = cgr_pkg::FK_ZERO;
        q_job.num  = s1_age_reg - k0;
        q_job.den  = k1 - k0;
        q_job.c0   = 32'd0;
        q_job.c1   = 32'd0;

        if (s1_init_reg)
        begin
            q_job.seg = 3'd0;
            q_job.upd = 1'b1;
            q_job.c0  = d_a[31:0];
        end
        else if ((32'(s1_seg_reg) >= 32'(last)) || (s1_age_reg <= ka))
        begin
            q_job.seg = s1_seg_reg;
        end
        else if (32'(s2) >= 32'(last))
        begin
            q_job.seg = s2[2:0];
            q_job.upd = 1'b1;
            q_job.c0  = adv ? d_b[31:0] : d_a[31:0];
        end
        else
        begin
            q_job.seg = s2[2:0];
            q_job.upd = 1'b1;
            q_job.c0  = adv ? d_b[31:0] : d_a[31:0];
            q_job.c1  = adv ? d_c[31:0] : d_b[31:0];
            if (k1 == k0)
            begin
                q_job.kind = cgr_pkg::FK_ONE;
            end
            else if (k1 < k0)
            begin
                q_job.kind = cgr_pkg::FK_ZERO;
            end
            else if ((s1_age_reg - k0) >= (k1 - k0))
            begin
                q_job.kind = cgr_pkg::FK_ONE;
            end
            else
            begin
                q_job.kind = cgr_pkg::FK_DIV;
            end
        end
    end

    assign q_push = s1_valid_reg;
endmodule

// ----- hw/rtl/cgr_fifo.sv -----
`timescale 1ns / 1ps

module cgr_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cgr_pkg::q_stat_t        wr,
    input  cgr_pkg::job_t           wr_job,
    input  logic                    pop,
    output logic                    rd_valid,
    output cgr_pkg::job_t           rd_job,
    output logic [cgr_pkg::QCW-1:0] count
);
    cgr_pkg::job_t mem [cgr_pkg::QDEPTH];
    logic [cgr_pkg::QPW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cgr_pkg::QCW-1:0] count_reg, count_next;
    logic do_pop;

    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem[rd_ptr_reg];
    assign count    = count_reg;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        count_next = count_reg + {{(cgr_pkg::QCW-1){1'b0}}, wr.push}
                               - {{(cgr_pkg::QCW-1){1'b0}}, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end
endmodule

// ----- hw/rtl/cgr_back.sv -----
`timescale 1ns / 1ps

module cgr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  cgr_pkg::job_t q_job,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [2:0]    segment_out,
    output logic          color_updated,
    output logic [7:0]    red_out,
    output logic [7:0]    green_out,
    output logic [7:0]    blue_out,
    output logic [7:0]    alpha_out
);
    localparam int NST = 17;

    logic back_en;

    logic [NST-1:0] st_valid_reg;
    logic [2:0]  st_seg  [NST];
    logic        st_upd  [NST];
    logic [1:0]  st_kind [NST];
    logic [15:0] st_den  [NST];
    logic [16:0] st_rem  [NST];
    logic [15:0] st_quo  [NST];
    logic [31:0] st_c0   [NST];
    logic [31:0] st_c1   [NST];

    logic        m_valid_reg;
    logic [2:0]  m_seg_reg;
    logic        m_upd_reg;
    logic [24:0] m_p0_reg [4];
    logic [24:0] m_p1_reg [4];

    logic        out_valid_reg;
    logic [2:0]  seg_reg;
    logic        upd_reg;
    logic [7:0]  ch_reg [4];

    logic [16:0] f;
    logic [25:0] sum [4];

    function automatic logic [17:0] div_step(input logic [16:0] rem, input logic [15:0] den);
        logic [17:0] t;
        t = {rem, 1'b0};
        if (t >= {2'b00, den})
        begin
            t = t - {2'b00, den};
            div_step = {t[16:0], 1'b1};
        end
        else
        begin
            div_step = {t[16:0], 1'b0};
        end
    endfunction

    assign back_en = !out_valid_reg || !out_stall;
    assign q_pop   = back_en && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= '0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            st_valid_reg  <= {st_valid_reg[NST-2:0], q_valid};
            m_valid_reg   <= st_valid_reg[NST-1];
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [17:0] r;
        if (back_en)
        begin
            st_seg[0]  <= q_job.seg;
            st_upd[0]  <= q_job.upd;
            st_kind[0] <= q_job.kind;
            st_den[0]  <= q_job.den;
            st_rem[0]  <= {1'b0, q_job.num};
            st_quo[0]  <= 16'd0;
            st_c0[0]   <= q_job.c0;
            st_c1[0]   <= q_job.c1;
            for (int i = 1; i < NST; i++)
            begin
                r = div_step(st_rem[i-1], st_den[i-1]);
                st_seg[i]  <= st_seg[i-1];
                st_upd[i]  <= st_upd[i-1];
                st_kind[i] <= st_kind[i-1];
                st_den[i]  <= st_den[i-1];
                st_rem[i]  <= r[17:1];
                st_quo[i]  <= {st_quo[i-1][14:0], r[0]};
                st_c0[i]   <= st_c0[i-1];
                st_c1[i]   <= st_c1[i-1];
            end

            m_seg_reg <= st_seg[NST-1];
            m_upd_reg <= st_upd[NST-1];
            for (int c = 0; c < 4; c++)
            begin
                m_p0_reg[c] <= {17'd0, st_c0[NST-1][31-8*c -: 8]} * {8'd0, 17'h10000 - f};
                m_p1_reg[c] <= {17'd0, st_c1[NST-1][31-8*c -: 8]} * {8'd0, f};
            end

            seg_reg <= m_seg_reg;
            upd_reg <= m_upd_reg;
            for (int c = 0; c < 4; c++)
            begin
                ch_reg[c] <= sum[c][23:16];
            end
        end
    end

    always_comb
    begin
        unique case (st_kind[NST-1])
            cgr_pkg::FK_ONE:  f = 17'h10000;
            cgr_pkg::FK_DIV:  f = {1'b0, st_quo[NST-1]};
            default:          f = 17'd0;
        endcase
        for (int c = 0; c < 4; c++)
        begin
            sum[c] = {1'b0, m_p0_reg[c]} + {1'b0, m_p1_reg[c]} + 26'd32768;
        end
    end

    assign out_valid     = out_valid_reg;
    assign segment_out   = seg_reg;
    assign color_updated = upd_reg;
    assign red_out       = ch_reg[0];
    assign green_out     = ch_reg[1];
    assign blue_out      = ch_reg[2];
    assign alpha_out     = ch_reg[3];
endmodule

// ----- sim/color_gradient_ramp_tb.sv -----
`timescale 1ns / 1ps

module color_gradient_ramp_tb;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int NSTOPS = 8;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        logic [1:0]  action;
        logic [2:0]  entry_index;
        logic [15:0] key_percent;
        logic [2:0]  current_segment;
        logic [7:0]  rgba [4];
    } ramp_req_t;

    typedef struct {
        logic [2:0] segment;
        logic       updated;
        logic [7:0] rgba [4];
    } ramp_colour_t;

    class ramp_scoreboard;
        logic [15:0]  key_tab  [NSTOPS];
        logic [7:0]   rgba_tab [NSTOPS][4];
        logic [3:0]   stop_count;
        ramp_colour_t pending_q [$];
        int           errors;
        int           checked;

        function void set_count(logic [3:0] v);
            stop_count = v;
        endfunction

        function void note_input(ramp_req_t t);
            ramp_colour_t r;
            int n;
            int s;
            logic [15:0] k0;
            logic [15:0] k1;
            logic [63:0] q;
            logic [16:0] f;
            logic [31:0] acc;
            n = (stop_count == 0) ? 1 : (stop_count > NSTOPS) ? NSTOPS : int'(stop_count);
            r.segment = 3'd0;
            r.updated = 1'b0;
            for (int c = 0; c < 4; c++)
                r.rgba[c] = 8'd0;
            case (t.action)
                cgr_pkg::ACT_LOAD:
                begin
                    key_tab[t.entry_index] = t.key_percent;
                    for (int c = 0; c < 4; c++)
                        rgba_tab[t.entry_index][c] = t.rgba[c];
                    return;
                end
                cgr_pkg::ACT_INIT:
                begin
                    r.updated = 1'b1;
                    for (int c = 0; c < 4; c++)
                        r.rgba[c] = rgba_tab[0][c];
                end
                cgr_pkg::ACT_EVAL:
                begin
                    s = int'(t.current_segment);
                    if (s >= n - 1 || t.key_percent <= key_tab[s])
                        r.segment = s[2:0];
                    else
                    begin
                        if (t.key_percent >= key_tab[s + 1])
                            s++;
                        r.segment = s[2:0];
                        r.updated = 1'b1;
                        if (s >= n - 1)
                        begin
                            for (int c = 0; c < 4; c++)
                                r.rgba[c] = rgba_tab[s][c];
                        end
                        else
                        begin
                            k0 = key_tab[s];
                            k1 = key_tab[s + 1];
                            if (k1 == k0)
                                f = 17'h10000;
                            else if (k1 < k0)
                                f = 17'd0;
                            else
                            begin
                                q = ({48'd0, t.key_percent - k0} << 16) / {48'd0, k1 - k0};
                                f = (q > 64'h10000) ? 17'h10000 : q[16:0];
                            end
                            for (int c = 0; c < 4; c++)
                            begin
                                acc = {24'd0, rgba_tab[s][c]} * (32'h10000 - {15'd0, f})
                                    + {24'd0, rgba_tab[s + 1][c]} * {15'd0, f} + 32'h8000;
                                r.rgba[c] = acc[23:16];
                            end
                        end
                    end
                end
                default:
                    return;
            endcase
            pending_q = {pending_q, r};
        endfunction

        function void check(ramp_colour_t got);
            ramp_colour_t exp;
            checked++;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result seg=%0d upd=%0d", $time, got.segment,
                         got.updated);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.segment !== exp.segment)
            begin
                $display("%0t: segment_out expected %0d actual %0d", $time, exp.segment,
                         got.segment);
                errors++;
            end
            if (got.updated !== exp.updated)
            begin
                $display("%0t: color_updated expected %0d actual %0d", $time, exp.updated,
                         got.updated);
                errors++;
            end
            for (int c = 0; c < 4; c++)
                if (got.rgba[c] !== exp.rgba[c])
                begin
                    $display("%0t: channel %0d expected %0d actual %0d", $time, c,
                             exp.rgba[c], got.rgba[c]);
                    errors++;
                end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       stop_count_we;
    logic [3:0] stop_count_wdata;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] action;
    logic [2:0] entry_index;
    logic [15:0] key_percent;
    logic [2:0] current_segment;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] segment_out;
    logic       color_updated;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    ramp_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;
    int  sent;

    color_gradient_ramp dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .stop_count_we    (stop_count_we),
        .stop_count_wdata (stop_count_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .entry_index      (entry_index),
        .key_percent      (key_percent),
        .current_segment  (current_segment),
        .red_in           (red_in),
        .green_in         (green_in),
        .blue_in          (blue_in),
        .alpha_in         (alpha_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .segment_out      (segment_out),
        .color_updated    (color_updated),
        .red_out          (red_out),
        .green_out        (green_out),
        .blue_out         (blue_out),
        .alpha_out        (alpha_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stall plus long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 80;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        ramp_colour_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.segment = segment_out;
            got.updated = color_updated;
            got.rgba[0] = red_out;
            got.rgba[1] = green_out;
            got.rgba[2] = blue_out;
            got.rgba[3] = alpha_out;
            sb.check(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send(ramp_req_t t);
        bit done;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            if ($urandom_range(99) < send_idle_pct)
                in_valid = 1'b0;
            else
            begin
                action          = t.action;
                entry_index     = t.entry_index;
                key_percent     = t.key_percent;
                current_segment = t.current_segment;
                red_in          = t.rgba[0];
                green_in        = t.rgba[1];
                blue_in         = t.rgba[2];
                alpha_in        = t.rgba[3];
                in_valid        = 1'b1;
                do
                    @(posedge clk);
                while (in_stall);
                sb.note_input(t);
                sent++;
                done = 1'b1;
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(logic [3:0] v);
        drain();
        stop_count_we    = 1'b1;
        stop_count_wdata = v;
        @(negedge clk);
        stop_count_we    = 1'b0;
        sb.set_count(v);
    endtask

    function automatic ramp_req_t make_req(logic [1:0] a, logic [2:0] idx, logic [15:0] k,
                                           logic [2:0] s);
        ramp_req_t t;
        t.action          = a;
        t.entry_index     = idx;
        t.key_percent     = k;
        t.current_segment = s;
        for (int c = 0; c < 4; c++)
            t.rgba[c] = 8'($urandom_range(255));
        return t;
    endfunction

    task automatic load_ramp();
        logic [15:0] k;
        k = 16'd0;
        for (int i = 0; i < NSTOPS; i++)
        begin
            if ($urandom_range(9) == 0)
                k = 16'($urandom);
            else if ($urandom_range(5) != 0)
                k = (k > 16'hFFFF - 16'h3000) ? k : k + 16'($urandom_range(16'h3000));
            send(make_req(cgr_pkg::ACT_LOAD, i[2:0], k, 3'($urandom_range(7))));
        end
    endtask

    task automatic random_phase(int items);
        ramp_req_t t;
        int r;
        int n;
        int s;
        n = (sb.stop_count == 0) ? 1 : (sb.stop_count > NSTOPS) ? NSTOPS
                                                                : int'(sb.stop_count);
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(99);
            if (r < 4)
            begin
                load_ramp();
                i += NSTOPS - 1;
            end
            else if (r < 12)
                send(make_req(cgr_pkg::ACT_LOAD, 3'($urandom_range(7)), 16'($urandom),
                              3'($urandom_range(7))));
            else if (r < 22)
                send(make_req(cgr_pkg::ACT_INIT, 3'($urandom_range(7)), 16'($urandom),
                              3'($urandom_range(7))));
            else if (r < 25)
            begin
                send(make_req(ACT_NONE, 3'($urandom_range(7)), 16'($urandom),
                              3'($urandom_range(7))));
                i--;
            end
            else
            begin
                s = ($urandom_range(4) == 0 || n < 2) ? $urandom_range(7)
                                                     : $urandom_range(n - 2);
                t = make_req(cgr_pkg::ACT_EVAL, 3'($urandom_range(7)), 16'($urandom),
                             s[2:0]);
                if ($urandom_range(3) == 0 && s + 1 < NSTOPS)
                    t.key_percent = sb.key_tab[s + $urandom_range(1)];
                send(t);
            end
        end
    endtask

    initial
    begin
        ramp_req_t t;
        logic [15:0] dkeys [NSTOPS];
        logic [3:0] counts [7];
        sb = new();
        sb.set_count(4'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        stop_count_we = 1'b0;
        stop_count_wdata = 4'd0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = cgr_pkg::ACT_EVAL;
        entry_index = 3'd0;
        key_percent = 16'd0;
        current_segment = 3'd0;
        red_in = 8'd0;
        green_in = 8'd0;
        blue_in = 8'd0;
        alpha_in = 8'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero-width, descending and full-range stops
        write_count(4'd8);
        dkeys = '{16'h0000, 16'h2000, 16'h2000, 16'h8000, 16'h6000, 16'hC000, 16'hF000,
                  16'hFFFF};
        for (int i = 0; i < NSTOPS; i++)
        begin
            t = make_req(cgr_pkg::ACT_LOAD, i[2:0], dkeys[i], 3'd0);
            for (int c = 0; c < 4; c++)
                t.rgba[c] = (i == 0) ? 8'h00 : (i == NSTOPS - 1) ? 8'hFF : t.rgba[c];
            send(t);
        end
        send(make_req(cgr_pkg::ACT_INIT, 3'd0, 16'd0, 3'd0));
        send(make_req(cgr_pkg::ACT_EVAL, 3'd0, 16'h0000, 3'd0));
        send(make_req(cgr_pkg::ACT_EVAL, 3'd0, 16'h1000, 3'd0));
        send(make_req(cgr_pkg::ACT_EVAL, 3'd0, 16'h2000, 3'd0));
        send(make_req(cgr_pkg::ACT_EVAL, 3'd0, 16'h2001, 3'd1));
        send(make_req(cgr_pkg::ACT_EVAL, 3'd0, 16'h7000, 3'd2));
        send(make_req(cgr_pkg::ACT_EVAL, 3'd0, 16'h9000, 3'd3));
        send(make_req(cgr_pkg::ACT_EVAL, 3'd0, 16'hFFFE, 3'd6));
        send(make_req(cgr_pkg::ACT_EVAL, 3'd0, 16'hFFFF, 3'd6));
        send(make_req(cgr_pkg::ACT_EVAL, 3'd0, 16'hFFFF, 3'd7));
        send(make_req(ACT_NONE, 3'd7, 16'hFFFF, 3'd7));
        send(make_req(cgr_pkg::ACT_EVAL, 3'd0, 16'h8000, 3'd0));

        counts = '{4'd0, 4'd15, 4'd2, 4'd5, 4'd9, 4'd1, 4'd8};
        for (int p = 0; p < 7; p++)
        begin
            write_count(counts[p]);
            send_idle_pct = (p < 2) ? 35 : (p < 5) ? 64 : 0;
            recv_idle_pct = (p < 2) ? 64 : (p < 5) ? 35 : 0;
            if (p == 3)
                hold_req = 1'b1;
            random_phase(50);
            if (p == 4)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                while (sb.pending_q.size() != 0)
                    @(negedge clk);
            end
            if (p == 6)
                hold_req = 1'b1;
            random_phase(50);
        end

        drain();
        $display("Covered %0d accepted inputs and %0d results over seven stop counts,",
                 sent, sb.checked);
        $display("with sender and receiver idling in turn and two long output hold-offs.");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
